@@ hw/rtl/esp_pkg.sv @@
`default_nettype none

package esp_pkg;

    localparam int NSTG = 21;

    localparam logic [31:0] F_LOG2E  = 32'h3FB8AA3B;
    localparam logic [31:0] F_HALF   = 32'h3F000000;
    localparam logic [31:0] F_ONE    = 32'h3F800000;
    localparam logic [31:0] F_LN2_HI = 32'h3F318000;
    localparam logic [31:0] F_LN2_LO = 32'hB95E8083;
    localparam logic [31:0] F_C0     = 32'h39506967;
    localparam logic [31:0] F_C1     = 32'h3AB743CE;
    localparam logic [31:0] F_C2     = 32'h3C088908;
    localparam logic [31:0] F_C3     = 32'h3D2AA9C1;
    localparam logic [31:0] F_C4     = 32'h3E2AAAAA;
    localparam logic [31:0] F_C5     = 32'h3F000000;
    localparam logic [31:0] F_QNAN   = 32'h7FC00000;
    localparam logic [31:0] F_PINF   = 32'h7F800000;
    localparam logic [31:0] F_QBIT   = 32'h00400000;

    localparam logic [1:0] SPC_NONE  = 2'd0;
    localparam logic [1:0] SPC_NAN   = 2'd1;
    localparam logic [1:0] SPC_OVER  = 2'd2;
    localparam logic [1:0] SPC_UNDER = 2'd3;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] acc;
        logic [31:0] aux;
        logic [31:0] sres;
        logic [7:0]  n;
        logic [1:0]  spc;
    } t_item;

    typedef struct packed {
        logic       over;
        logic       under;
        logic [7:0] n;
    } t_floor;

    function automatic logic [26:0] shr_sticky(input logic [26:0] m, input logic [4:0] sh);
        logic [26:0] mask;
        mask = (27'd1 << sh) - 27'd1;
        shr_sticky = (m >> sh) | {26'd0, |(m & mask)};
    endfunction

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] lz;
        lz = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) begin
                lz = 6'(47 - i);
            end
        end
        lzc48 = lz;
    endfunction

    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] lz;
        lz = 5'd0;
        for (int i = 0; i < 27; i++) begin
            if (v[i]) begin
                lz = 5'(26 - i);
            end
        end
        lzc27 = lz;
    endfunction

    function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] e,
                                               input logic [26:0] m);
        logic [26:0] mm;
        logic [7:0] ef;
        logic inc;
        logic signed [11:0] sh;
        logic [30:0] mag;
        mm = m;
        ef = 8'd0;
        sh = 12'sd0;
        if (m == 27'd0) begin
            round_pack = {s, 31'd0};
        end else if (e >= 12'sd255) begin
            round_pack = {s, 8'hFF, 23'd0};
        end else begin
            if (e <= 12'sd0) begin
                sh = 12'sd1 - e;
                mm = shr_sticky(m, (sh > 12'sd27) ? 5'd27 : sh[4:0]);
                ef = 8'd0;
            end else begin
                ef = e[7:0];
            end
            inc = mm[2] & (mm[1] | mm[0] | mm[3]);
            mag = {ef, mm[25:3]} + {30'd0, inc};
            round_pack = {s, mag};
        end
    endfunction

    function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
        logic s;
        logic [7:0] ea;
        logic [7:0] eb;
        logic na, nb, ia, ib, za, zb;
        logic [23:0] ma;
        logic [23:0] mb;
        logic [47:0] p;
        logic [47:0] pn;
        logic [5:0] lz;
        logic signed [11:0] e;
        s = a[31] ^ b[31];
        na = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        nb = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        ia = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        ib = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        za = a[30:0] == 31'd0;
        zb = b[30:0] == 31'd0;
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        p = ma * mb;
        lz = lzc48(p);
        pn = p << lz;
        e = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126 - $signed({6'd0, lz});
        if (na || nb || (ia && zb) || (ib && za)) begin
            fmul = F_QNAN;
        end else if (ia || ib) begin
            fmul = {s, 8'hFF, 23'd0};
        end else if (za || zb) begin
            fmul = {s, 31'd0};
        end else begin
            fmul = round_pack(s, e, {pn[47:22], |pn[21:0]});
        end
    endfunction

    function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
        logic na, nb, ia, ib, za, zb;
        logic [7:0] ea;
        logic [7:0] eb;
        logic [26:0] ma;
        logic [26:0] mb;
        logic [26:0] ml;
        logic [26:0] ms;
        logic [7:0] el;
        logic [7:0] d;
        logic sl, ss;
        logic [27:0] sum;
        logic [26:0] m;
        logic [4:0] lz;
        logic signed [11:0] e;
        na = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        nb = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        ia = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        ib = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        za = a[30:0] == 31'd0;
        zb = b[30:0] == 31'd0;
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma = {a[30:23] != 8'd0, a[22:0], 3'd0};
        mb = {b[30:23] != 8'd0, b[22:0], 3'd0};
        if ({eb, mb} > {ea, ma}) begin
            ml = mb; el = eb; sl = b[31];
            ms = ma; d = eb - ea; ss = a[31];
        end else begin
            ml = ma; el = ea; sl = a[31];
            ms = mb; d = ea - eb; ss = b[31];
        end
        ms = shr_sticky(ms, (d > 8'd27) ? 5'd27 : d[4:0]);
        if (sl == ss) begin
            sum = {1'b0, ml} + {1'b0, ms};
        end else begin
            sum = {1'b0, ml} - {1'b0, ms};
        end
        lz = lzc27(sum[26:0]);
        if (sum[27]) begin
            m = {sum[27:2], sum[1] | sum[0]};
            e = $signed({4'd0, el}) + 12'sd1;
        end else begin
            m = sum[26:0] << lz;
            e = $signed({4'd0, el}) - $signed({7'd0, lz});
        end
        if (na || nb || (ia && ib && (a[31] != b[31]))) begin
            fadd = F_QNAN;
        end else if (ia) begin
            fadd = a;
        end else if (ib) begin
            fadd = b;
        end else if (za && zb) begin
            fadd = {a[31] & b[31], 31'd0};
        end else if (sum == 28'd0) begin
            fadd = 32'd0;
        end else begin
            fadd = round_pack(sl, e, m);
        end
    endfunction

    function automatic t_floor floor_int(input logic [31:0] t);
        logic s;
        logic [7:0] te;
        logic [23:0] tm;
        logic [4:0] sh;
        logic [7:0] ip;
        logic fr;
        logic signed [9:0] v;
        t_floor f;
        s = t[31];
        te = t[30:23];
        tm = {1'b1, t[22:0]};
        sh = 5'd23 - {2'b0, te[2:0] - 3'd7};
        ip = 8'(tm >> sh);
        fr = |(tm & ((24'd1 << sh) - 24'd1));
        f.over = 1'b0;
        f.under = 1'b0;
        v = 10'sd0;
        if (te >= 8'd135) begin
            f.over = ~s;
            f.under = s;
        end else if (te < 8'd127) begin
            v = (s && (t[30:0] != 31'd0)) ? -10'sd1 : 10'sd0;
        end else begin
            if (s) begin
                v = 10'sd0 - $signed({2'b0, ip}) - $signed({9'd0, fr});
            end else begin
                v = $signed({2'b0, ip});
            end
            f.over = v > 10'sd127;
            f.under = v < -10'sd126;
        end
        f.n = v[7:0];
        floor_int = f;
    endfunction

    function automatic logic [31:0] int_to_float(input logic [7:0] n);
        logic [7:0] mag;
        logic [2:0] p;
        logic [30:0] tmp;
        mag = n[7] ? (8'd0 - n) : n;
        p = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (mag[i]) begin
                p = 3'(i);
            end
        end
        tmp = {mag, 23'd0} >> p;
        if (mag == 8'd0) begin
            int_to_float = 32'd0;
        end else begin
            int_to_float = {n[7], 8'd127 + {5'd0, p}, tmp[22:0]};
        end
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/exp_single_polynomial.sv @@
`default_nettype none

// Single-precision e^x with at most two rounded IEEE operations per pipeline stage. The pipeline is
// 21 stages deep, and one item can be taken every cycle while the output is not held. When the
// output is held, the whole pipeline holds with it. A NaN argument returns as a quiet NaN; a
// scale exponent beyond the normal range saturates to +inf or +0 and raises the range flag.
module exp_single_polynomial
    import esp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_x_bits,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_result_bits,
    output logic             o_range_flag
);

    t_item r_stg [NSTG];
    t_item n_stg [NSTG];
    logic [NSTG-1:0] r_vld;
    logic en;

    assign en = ~r_vld[NSTG-1] | i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[NSTG-1];
    assign o_result_bits = r_stg[NSTG-1].acc;
    assign o_range_flag = (r_stg[NSTG-1].spc == SPC_OVER) || (r_stg[NSTG-1].spc == SPC_UNDER);

    always_comb begin
        t_item cur;
        t_item nxt;
        t_floor fl;
        for (int k = 0; k < NSTG; k++) begin
            if (k == 0) begin
                cur = '0;
                cur.x = i_x_bits;
            end else begin
                cur = r_stg[k-1];
            end
            nxt = cur;
            fl = floor_int(cur.acc);
            unique case (k)
                0: begin
                    nxt.acc = fmul(F_LOG2E, cur.x);
                    nxt.sres = cur.x | F_QBIT;
                    nxt.spc = ((cur.x[30:23] == 8'hFF) && (cur.x[22:0] != 23'd0)) ?
                              SPC_NAN : SPC_NONE;
                end
                1: nxt.acc = fadd(cur.acc, F_HALF);
                2: begin
                    if (cur.spc == SPC_NONE) begin
                        if (fl.over) begin
                            nxt.spc = SPC_OVER;
                            nxt.sres = F_PINF;
                        end else if (fl.under) begin
                            nxt.spc = SPC_UNDER;
                            nxt.sres = 32'd0;
                        end
                    end
                    nxt.n = fl.n;
                    nxt.acc = int_to_float(fl.n);
                end
                3: begin
                    nxt.acc = fmul(cur.acc, F_LN2_HI);
                    nxt.aux = fmul(cur.acc, F_LN2_LO);
                end
                4: nxt.x = fadd(cur.x, {~cur.acc[31], cur.acc[30:0]});
                5: nxt.x = fadd(cur.x, {~cur.aux[31], cur.aux[30:0]});
                6: nxt.acc = fmul(F_C0, cur.x);
                7: nxt.acc = fadd(cur.acc, F_C1);
                9: nxt.acc = fadd(cur.acc, F_C2);
                11: nxt.acc = fadd(cur.acc, F_C3);
                13: nxt.acc = fadd(cur.acc, F_C4);
                15: nxt.acc = fadd(cur.acc, F_C5);
                8, 10, 12, 14, 16, 17: nxt.acc = fmul(cur.acc, cur.x);
                18: nxt.acc = fadd(cur.acc, cur.x);
                19: nxt.acc = fadd(cur.acc, F_ONE);
                default: begin
                    nxt.acc = (cur.spc == SPC_NONE) ?
                              fmul({1'b0, cur.n + 8'd127, 23'd0}, cur.acc) : cur.sres;
                end
            endcase
            n_stg[k] = nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NSTG; k++) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

endmodule

`default_nettype wire
